/* design/frwt_pkg.sv */
// Shared types and constants for the fractional rank unit.
`timescale 1ns / 1ps

package frwt_pkg;

    localparam int KEY_W  = 32;
    localparam int RANK_W = 8;
    localparam int POS_W  = 6;
    localparam int GRP_W  = 8;
    localparam int PSUM_W = 4;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_FIN  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic accept;
        logic finish;
        logic emit_load;
        logic set_clear;
    } frwt_cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_last;
    } frwt_status_t;

endpackage

/* design/frwt_ctrl.sv */
// Sequencer for loading keys and emitting ranks.
`timescale 1ns / 1ps

module frwt_ctrl
    import frwt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_last_in,
    output logic         s_ready,
    input  frwt_status_t status,
    output frwt_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    last_next  = s_last_in;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last) begin
                        cmd.set_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/frwt_dpath.sv */
// Key cells, tie and greater counters, tally tree and result register.
`timescale 1ns / 1ps

module frwt_dpath
    import frwt_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  frwt_cmd_t                cmd,
    output frwt_status_t             status,
    input  logic signed [KEY_W-1:0]  s_key,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [RANK_W-1:0]        m_rank_doubled,
    output logic [POS_W-1:0]         m_position,
    output logic                     m_truncated,
    output logic                     m_last_out
);

    localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int NG = (MAX_KEYS + GRP_W - 1) / GRP_W;

    logic signed [KEY_W-1:0] key_reg [MAX_KEYS];
    logic [NW-1:0]           gt_reg  [MAX_KEYS];
    logic [NW-1:0]           eq_reg  [MAX_KEYS];
    logic [PSUM_W-1:0]       pgt_reg [NG];
    logic [PSUM_W-1:0]       peq_reg [NG];
    logic [PSUM_W-1:0]       pgt_next [NG];
    logic [PSUM_W-1:0]       peq_next [NG];

    logic [NW-1:0]     size_reg;
    logic              ovf_reg;
    logic [IW-1:0]     slot_reg;
    logic              wr_reg;
    logic [IW-1:0]     emit_idx_reg;
    logic              m_valid_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              trunc_reg;
    logic              last_out_reg;

    logic [MAX_KEYS-1:0] lt_vec, gt_vec, eq_vec;
    logic [NW-1:0]       gt_sum, eq_sum;
    logic [RANK_W:0]     rank_calc;
    logic                full;

    assign full = (size_reg == NW'(MAX_KEYS));

    always_comb begin
        for (int j = 0; j < MAX_KEYS; j++) begin
            logic valid_j;
            valid_j   = (NW'(j) < size_reg);
            lt_vec[j] = valid_j && (key_reg[j] <  s_key);
            gt_vec[j] = valid_j && (key_reg[j] >  s_key);
            eq_vec[j] = valid_j && (key_reg[j] == s_key);
        end
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            pgt_next[g] = '0;
            peq_next[g] = '0;
            for (int b = 0; b < GRP_W; b++) begin
                if (g * GRP_W + b < MAX_KEYS) begin
                    pgt_next[g] = pgt_next[g] + PSUM_W'(gt_vec[g * GRP_W + b]);
                    peq_next[g] = peq_next[g] + PSUM_W'(eq_vec[g * GRP_W + b]);
                end
            end
        end
    end

    always_comb begin
        gt_sum = '0;
        eq_sum = NW'(1);
        for (int g = 0; g < NG; g++) begin
            gt_sum = gt_sum + NW'(pgt_reg[g]);
            eq_sum = eq_sum + NW'(peq_reg[g]);
        end
    end

    assign rank_calc = ((RANK_W+1)'(size_reg) << 1) + (RANK_W+1)'(1)
                     - ((RANK_W+1)'(gt_reg[0]) << 1) - (RANK_W+1)'(eq_reg[0]);

    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.emit_last = ((NW'(emit_idx_reg) + NW'(1)) == size_reg);

    // Cell storage: compare on accept, fill the new cell on finish,
    // and shift toward cell zero while results go out.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (!full) begin
                for (int j = 0; j < MAX_KEYS; j++) begin
                    gt_reg[j] <= gt_reg[j] + NW'(lt_vec[j]);
                    eq_reg[j] <= eq_reg[j] + NW'(eq_vec[j]);
                end
                key_reg[size_reg[IW-1:0]] <= s_key;
            end
            for (int g = 0; g < NG; g++) begin
                pgt_reg[g] <= pgt_next[g];
                peq_reg[g] <= peq_next[g];
            end
            slot_reg <= size_reg[IW-1:0];
        end else if (cmd.finish) begin
            if (wr_reg) begin
                gt_reg[slot_reg] <= gt_sum;
                eq_reg[slot_reg] <= eq_sum;
            end
        end else if (cmd.emit_load) begin
            for (int j = 0; j < MAX_KEYS - 1; j++) begin
                gt_reg[j] <= gt_reg[j + 1];
                eq_reg[j] <= eq_reg[j + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= '0;
            ovf_reg      <= 1'b0;
            wr_reg       <= 1'b0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.accept) begin
                wr_reg <= !full;
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    size_reg <= size_reg + NW'(1);
                end
            end
            if (cmd.emit_load) begin
                emit_idx_reg <= status.emit_last ? '0 : emit_idx_reg + IW'(1);
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.set_clear) begin
                size_reg <= '0;
                ovf_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            rank_reg     <= rank_calc[RANK_W-1:0];
            pos_reg      <= POS_W'(emit_idx_reg);
            trunc_reg    <= ovf_reg;
            last_out_reg <= status.emit_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_rank_doubled = rank_reg;
    assign m_position     = pos_reg;
    assign m_truncated    = trunc_reg;
    assign m_last_out     = last_out_reg;

`ifndef NO_ASSERTIONS
    a_size_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        size_reg <= NW'(MAX_KEYS))
        else $error("Set size exceeds the key capacity.");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> size_reg != '0)
        else $error("A rank was emitted from an empty set.");

    a_size_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && !full |=> size_reg == $past(size_reg) + NW'(1))
        else $error("An accepted key was not added to the set.");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load && status.emit_last |=> size_reg == '0 && !ovf_reg)
        else $error("The set was not cleared after its last rank.");
`endif

endmodule

/* design/fractional_rank_with_ties_unit.sv */
// Top level of the fractional rank unit with averaged ties.
//
// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_key, s_last_in
// m_        out        m_valid, m_ready, m_rank_doubled, m_position, m_truncated, m_last_out
//
// Each key request is compared against every stored cell and partial counts are tallied
// in the IDLE state; the FIN state then sums the tally into the new cell.
// After the closing key, results leave at one per cycle while m_ready is high;
// the input stays stalled until the last result is loaded into the output register.
// Reset clears the set size, overflow flag, sequencer and output valid.
`timescale 1ns / 1ps

module fractional_rank_with_ties_unit
    import frwt_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [KEY_W-1:0] s_key,
    input  logic                    s_last_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [RANK_W-1:0]       m_rank_doubled,
    output logic [POS_W-1:0]        m_position,
    output logic                    m_truncated,
    output logic                    m_last_out
);

    frwt_cmd_t    cmd;
    frwt_status_t status;

    frwt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_last_in (s_last_in),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    frwt_dpath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_key          (s_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rank_doubled (m_rank_doubled),
        .m_position     (m_position),
        .m_truncated    (m_truncated),
        .m_last_out     (m_last_out)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the fractional rank unit with averaged ties.
`timescale 1ns / 1ps

module tb_top;
    import frwt_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int RAND_ITEMS = 400;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_WAIT  = 20;
    localparam int DIR_ROWS   = 23;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [POS_W-1:0]  pos;
        logic              trunc;
        logic              last;
    } rank_res_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    last;
        logic                    typed;
        logic [RANK_W-1:0]       rank;
    } stim_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [KEY_W-1:0] s_key = '0;
    logic                    s_last_in = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [RANK_W-1:0]       m_rank_doubled;
    logic [POS_W-1:0]        m_position;
    logic                    m_truncated;
    logic                    m_last_out;

    logic signed [KEY_W-1:0] held_keys [CAPACITY];
    logic [6:0]              greater_tally [CAPACITY];
    logic [6:0]              equal_tally [CAPACITY];
    int                      held_count = 0;
    logic                    overflow_flag = 1'b0;
    rank_res_t               ranks_pending [$];

    int mismatches = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{KEY_MIN, 1'b1, 1'b1, 8'd2},
        '{KEY_MAX, 1'b1, 1'b1, 8'd2},
        '{32'sd0,  1'b1, 1'b1, 8'd2},
        '{-32'sd1, 1'b1, 1'b1, 8'd2},
        '{KEY_MAX, 1'b0, 1'b0, 8'd0},
        '{KEY_MIN, 1'b0, 1'b0, 8'd0},
        '{32'sd0,  1'b0, 1'b0, 8'd0},
        '{-32'sd1, 1'b0, 1'b0, 8'd0},
        '{32'sd1,  1'b1, 1'b0, 8'd0},
        '{32'sd5,  1'b0, 1'b0, 8'd0},
        '{32'sd5,  1'b0, 1'b0, 8'd0},
        '{32'sd5,  1'b1, 1'b0, 8'd0},
        '{32'sd3,  1'b0, 1'b0, 8'd0},
        '{32'sd2,  1'b0, 1'b0, 8'd0},
        '{32'sd1,  1'b0, 1'b0, 8'd0},
        '{32'sd0,  1'b1, 1'b0, 8'd0},
        '{-32'sd2, 1'b0, 1'b0, 8'd0},
        '{-32'sd1, 1'b1, 1'b0, 8'd0},
        '{32'sd7,  1'b0, 1'b0, 8'd0},
        '{-32'sd7, 1'b0, 1'b0, 8'd0},
        '{32'sd7,  1'b0, 1'b0, 8'd0},
        '{-32'sd7, 1'b0, 1'b0, 8'd0},
        '{32'sd7,  1'b1, 1'b0, 8'd0}
    };

    fractional_rank_with_ties_unit #(
        .MAX_KEYS(CAPACITY)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key         (s_key),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rank_doubled(m_rank_doubled),
        .m_position    (m_position),
        .m_truncated   (m_truncated),
        .m_last_out    (m_last_out)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int tally_key(logic signed [KEY_W-1:0] key, logic last);
        int slot;
        int total;
        rank_res_t res;
        if (held_count < CAPACITY) begin
            slot = held_count;
            held_keys[slot] = key;
            greater_tally[slot] = 7'd0;
            equal_tally[slot] = 7'd1;
            for (int j = 0; j < slot; j++) begin
                if (held_keys[j] > key) begin
                    greater_tally[slot] = greater_tally[slot] + 7'd1;
                end else if (held_keys[j] == key) begin
                    equal_tally[slot] = equal_tally[slot] + 7'd1;
                    equal_tally[j] = equal_tally[j] + 7'd1;
                end else begin
                    greater_tally[j] = greater_tally[j] + 7'd1;
                end
            end
            held_count = slot + 1;
        end else begin
            overflow_flag = 1'b1;
        end
        if (!last) return 0;
        total = held_count;
        for (int j = 0; j < total; j++) begin
            res.rank  = RANK_W'(2 * total + 1 - 2 * int'(greater_tally[j])
                                - int'(equal_tally[j]));
            res.pos   = POS_W'(j);
            res.trunc = overflow_flag;
            res.last  = (j == total - 1);
            ranks_pending = {ranks_pending, res};
        end
        for (int j = 0; j < CAPACITY; j++) begin
            greater_tally[j] = 7'd0;
            equal_tally[j] = 7'd0;
        end
        held_count = 0;
        overflow_flag = 1'b0;
        return total;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key(int mode);
        logic signed [KEY_W-1:0] k;
        k = $urandom;
        if (mode == 1) begin
            k = $signed($urandom_range(0, 8)) - 32'sd4;
        end else if (mode == 2) begin
            case ($urandom_range(0, 4))
                0: k = KEY_MIN;
                1: k = KEY_MAX;
                2: k = 32'sd0;
                3: k = -32'sd1;
                default: k = $urandom;
            endcase
        end
        return k;
    endfunction

    task automatic report_rank(string what, rank_res_t want, rank_res_t got);
        mismatches++;
        $display("%s: want rank %0d pos %0d trunc %0d last %0d, %s %0d pos %0d trunc %0d last %0d",
                 what, want.rank, want.pos, want.trunc, want.last,
                 "got rank", got.rank, got.pos, got.trunc, got.last);
    endtask

    task automatic send_key(logic signed [KEY_W-1:0] key, logic last, logic typed,
                            logic [RANK_W-1:0] rank);
        int gap;
        int produced;
        rank_res_t fixed;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        s_key = key;
        s_last_in = last;
        s_valid = 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        produced = tally_key(key, last);
        if (typed && produced == 1) begin
            void'(ranks_pending.pop_back());
            fixed.rank  = rank;
            fixed.pos   = '0;
            fixed.trunc = 1'b0;
            fixed.last  = 1'b1;
            ranks_pending = {ranks_pending, fixed};
        end
        @(negedge aclk);
    endtask

    task automatic drain_ranks();
        s_valid = 1'b0;
        while (ranks_pending.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin : receiver
        logic [15:0] stall_pat;
        int          phase;
        int          mode;
        if (!aresetn) begin
            stall_pat = 16'hFFFF;
            phase = 0;
            m_ready <= 1'b0;
        end else begin
            if (phase % 64 == 0) begin
                mode = $urandom_range(0, 2);
                case (mode)
                    0: stall_pat = 16'hFFFF;
                    1: stall_pat = 16'($urandom);
                    default: stall_pat = 16'($urandom & $urandom);
                endcase
                stall_pat[0] = 1'b1;
            end
            m_ready <= stall_pat[phase % 16];
            phase++;
        end
    end

    always @(posedge aclk) begin : result_check
        rank_res_t got;
        rank_res_t want;
        if (aresetn && m_valid && m_ready) begin
            got.rank  = m_rank_doubled;
            got.pos   = m_position;
            got.trunc = m_truncated;
            got.last  = m_last_out;
            if (ranks_pending.size() == 0) begin
                report_rank("unexpected result", '0, got);
            end else begin
                want = ranks_pending.pop_front();
                if (got.rank !== want.rank || got.pos !== want.pos ||
                    got.trunc !== want.trunc || got.last !== want.last) begin
                    report_rank("result mismatch", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int sent;
        int len;
        int mode;
        bit first_set;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_key(dir_rows[i].key, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].rank);
        end
        drain_ranks();

        sent = 0;
        first_set = 1'b1;
        while (sent < RAND_ITEMS) begin
            if (first_set) begin
                len = CAPACITY + 2;
            end else if ($urandom_range(0, 11) == 0) begin
                len = $urandom_range(CAPACITY - 4, CAPACITY + 6);
            end else begin
                len = $urandom_range(1, 10);
            end
            first_set = 1'b0;
            mode = $urandom_range(0, 2);
            for (int i = 0; i < len; i++) begin
                send_key(pick_key(mode), i == len - 1, 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 9) == 0) begin
                drain_ranks();
            end
        end
        s_valid = 1'b0;

        while (ranks_pending.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (mismatches == 0 && ranks_pending.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* fractional_rank_with_ties_unit.f */
design/frwt_pkg.sv
design/frwt_ctrl.sv
design/frwt_dpath.sv
design/fractional_rank_with_ties_unit.sv
tb/sv/tb_top.sv
